// ----- sv/bmhq_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the binary min-heap queue unit
package bmhq_pkg;

	typedef enum logic [1:0] {
		REQ_INSERT   = 2'd0,
		REQ_EXTRACT  = 2'd1,
		REQ_DECREASE = 2'd2,
		REQ_DELETE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	localparam int unsigned LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	typedef struct packed {
		req_t               req_type;
		logic signed [31:0] key_value;
		logic [5:0]         entry_index;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] extracted_key;
		logic signed [31:0] current_min;
		logic [6:0]         entry_count;
		status_t            status;
	} out_beat_t;

endpackage

// ----- sv/binary_min_heap_queue_unit.sv -----
`timescale 1ns / 1ps
// Binary min-heap priority queue with its keys in one on-chip memory. One request is taken at a
// time and in_stall stays high until it is done; an item passes through an accept step, a
// registered memory read and then a compare and write back for every heap level walked, a step
// to start a pop and one to load the moved entry for an extract or delete, and a step that hands
// over the result once the output register is free. The finished result sits in an output
// register while the next request is accepted. The moving key is kept in a register and written
// once per level, so a single write port suffices and no entry is read while a newer value for
// it is held.
module binary_min_heap_queue_unit #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [6:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bmhq_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bmhq_pkg::out_beat_t  out_data
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CXW  = AW + 2;
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
	localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
	localparam logic signed [63:0] KEY_MAX_64 = 64'(KEY_MAX);
	localparam logic signed [31:0] EMPTY_MIN = KEY_MAX_64[31:0];

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_POP_RD,
		S_POP_LD,
		S_DN_RD,
		S_DN_CMP,
		S_FIN
	} state_t;

	function automatic logic signed [31:0] to_out(input logic signed [KEY_WIDTH-1:0] k);
		logic signed [63:0] w;
		w = 64'(k);
		return w[31:0];
	endfunction

	logic signed [KEY_WIDTH-1:0] mem [CAPACITY];

	state_t                      state_q;
	logic [CW-1:0]               count_q;
	logic [6:0]                  limit_q;
	logic [AW-1:0]               pos_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic signed [KEY_WIDTH-1:0] root_q;
	logic signed [KEY_WIDTH-1:0] extracted_q;
	bmhq_pkg::status_t           status_q;
	logic                        del_q;
	logic                        out_valid_q;
	bmhq_pkg::out_beat_t         out_q;

	logic signed [KEY_WIDTH-1:0] rd_a_q;
	logic signed [KEY_WIDTH-1:0] rd_b_q;

	logic                        mem_we;
	logic [AW-1:0]               mem_wa;
	logic signed [KEY_WIDTH-1:0] mem_wd;
	logic [AW-1:0]               ra_a;
	logic [AW-1:0]               ra_b;

	logic [63:0]                 kv_64;
	logic signed [KEY_WIDTH-1:0] in_key;
	logic [CMPW-1:0]             lim_w;
	logic [CMPW-1:0]             idx_w;
	logic [CMPW-1:0]             cnt_w;
	logic [CW-1:0]               cnt_m1;
	logic [AW-1:0]               pos_m1;
	logic [AW-1:0]               parent;
	logic [CXW-1:0]              lchild;
	logic [CXW-1:0]              rchild;
	logic                        l_ok;
	logic                        r_ok;
	logic                        take_l;
	logic                        take_r;
	logic signed [KEY_WIDTH-1:0] best_v;
	logic                        accept;
	logic                        out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// key and range decode
	always_comb begin
		kv_64  = {32'b0, in_data.key_value};
		in_key = kv_64[KEY_WIDTH-1:0];
		cnt_w  = CMPW'(count_q);
		idx_w  = CMPW'(in_data.entry_index);
		lim_w  = (CMPW'(limit_q) > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : CMPW'(limit_q);
		cnt_m1 = count_q - CW'(1);
		pos_m1 = pos_q - AW'(1);
		parent = pos_m1 >> 1;
		lchild = (CXW'(pos_q) << 1) | CXW'(1);
		rchild = lchild + CXW'(1);
		l_ok   = lchild < CXW'(count_q);
		r_ok   = rchild < CXW'(count_q);
		take_l = l_ok && (rd_a_q < key_q);
		best_v = take_l ? rd_a_q : key_q;
		take_r = r_ok && (rd_b_q < best_v);
		if (take_r) begin
			best_v = rd_b_q;
		end
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_q;
		mem_wd = key_q;
		ra_a   = parent;
		ra_b   = rchild[AW-1:0];
		case (state_q)
			S_UP_RD: begin
				if (pos_q == AW'(0)) begin
					mem_we = 1'b1;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (!(rd_a_q <= key_q)) begin
					mem_wd = rd_a_q;
				end
			end
			S_POP_RD: begin
				ra_a = cnt_m1[AW-1:0];
			end
			S_DN_RD: begin
				ra_a = lchild[AW-1:0];
				if (!l_ok) begin
					mem_we = 1'b1;
				end
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				mem_wd = best_v;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_a_q <= mem[ra_a];
		rd_b_q <= mem[ra_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			limit_q     <= bmhq_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
			del_q       <= 1'b0;
			pos_q       <= '0;
			key_q       <= '0;
			root_q      <= '0;
			extracted_q <= KEY_MAX;
			status_q    <= bmhq_pkg::ST_OK;
			out_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we && mem_wa == AW'(0)) begin
				root_q <= mem_wd;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						extracted_q <= (in_data.req_type == bmhq_pkg::REQ_EXTRACT &&
							count_q != CW'(0)) ? root_q : KEY_MAX;
						del_q       <= (in_data.req_type == bmhq_pkg::REQ_DELETE);
						case (in_data.req_type)
							bmhq_pkg::REQ_INSERT: begin
								if (cnt_w >= lim_w) begin
									status_q <= bmhq_pkg::ST_OVERFLOW;
									state_q  <= S_FIN;
								end else begin
									status_q <= bmhq_pkg::ST_OK;
									key_q    <= in_key;
									pos_q    <= count_q[AW-1:0];
									count_q  <= count_q + CW'(1);
									state_q  <= S_UP_RD;
								end
							end
							bmhq_pkg::REQ_EXTRACT: begin
								if (count_q == CW'(0)) begin
									status_q <= bmhq_pkg::ST_EMPTY;
									state_q  <= S_FIN;
								end else begin
									status_q <= bmhq_pkg::ST_OK;
									state_q  <= S_POP_RD;
								end
							end
							bmhq_pkg::REQ_DECREASE, bmhq_pkg::REQ_DELETE: begin
								if (idx_w >= cnt_w) begin
									status_q <= bmhq_pkg::ST_BAD_INDEX;
									state_q  <= S_FIN;
								end else begin
									status_q <= bmhq_pkg::ST_OK;
									key_q    <= (in_data.req_type == bmhq_pkg::REQ_DELETE) ?
										KEY_MIN : in_key;
									pos_q    <= idx_w[AW-1:0];
									state_q  <= S_UP_RD;
								end
							end
							default: begin
								status_q <= bmhq_pkg::ST_OK;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_UP_RD: begin
					if (pos_q == AW'(0)) begin
						state_q <= del_q ? S_POP_RD : S_FIN;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (rd_a_q <= key_q) begin
						state_q <= del_q ? S_POP_RD : S_FIN;
					end else begin
						pos_q   <= parent;
						state_q <= S_UP_RD;
					end
				end
				S_POP_RD: begin
					count_q <= cnt_m1;
					state_q <= (cnt_m1 == CW'(0)) ? S_FIN : S_POP_LD;
				end
				S_POP_LD: begin
					key_q   <= rd_a_q;
					pos_q   <= '0;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= l_ok ? S_DN_CMP : S_FIN;
				end
				S_DN_CMP: begin
					if (take_l || take_r) begin
						pos_q   <= take_r ? rchild[AW-1:0] : lchild[AW-1:0];
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q.extracted_key <= to_out(extracted_q);
						out_q.current_min   <= (count_q != CW'(0)) ? to_out(root_q) : EMPTY_MIN;
						out_q.entry_count   <= 7'(count_q);
						out_q.status        <= status_q;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("held count above capacity");

	a_write_in_sift: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_UP_RD || state_q == S_UP_CMP ||
			state_q == S_DN_RD || state_q == S_DN_CMP))
		else $error("heap memory written outside a sift");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted beat not taken into work");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.entry_count == 7'd0) |-> out_data.current_min == EMPTY_MIN)
		else $error("empty heap reports a minimum");

endmodule

// ----- tb/tb_binary_min_heap_queue_unit.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the binary min-heap queue unit with a scoreboard class
module tb_binary_min_heap_queue_unit;

	localparam int unsigned CAPACITY = 64;
	localparam logic signed [31:0] KEY_TOP = 32'sh7fffffff;
	localparam logic signed [31:0] KEY_BOTTOM = 32'sh80000000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 125;

	class heap_scoreboard;
		logic signed [31:0] keys [CAPACITY];
		int unsigned held;
		int unsigned cap_limit;
		bmhq_pkg::out_beat_t expected_q [$];
		int unsigned errors;

		function new();
			held = 0;
			cap_limit = 32'(bmhq_pkg::LIMIT_RESET);
			errors = 0;
			foreach (keys[i]) keys[i] = '0;
		endfunction

		function void set_limit(logic [6:0] v);
			cap_limit = 32'(v);
		endfunction

		function void swap_keys(int unsigned a, int unsigned b);
			logic signed [31:0] t;
			t = keys[a];
			keys[a] = keys[b];
			keys[b] = t;
		endfunction

		function void sift_up(int unsigned pos);
			int unsigned up;
			while (pos != 0) begin
				up = (pos - 1) / 2;
				if (keys[up] <= keys[pos])
					break;
				swap_keys(pos, up);
				pos = up;
			end
		endfunction

		function void sift_down(int unsigned pos);
			int unsigned l, r, best;
			forever begin
				l = 2 * pos + 1;
				r = l + 1;
				best = pos;
				if (l < held && keys[l] < keys[best])
					best = l;
				if (r < held && keys[r] < keys[best])
					best = r;
				if (best == pos)
					break;
				swap_keys(pos, best);
				pos = best;
			end
		endfunction

		function logic signed [31:0] pop_root();
			logic signed [31:0] root;
			root = keys[0];
			held--;
			if (held > 0) begin
				keys[0] = keys[held];
				sift_down(0);
			end
			return root;
		endfunction

		function void note_request(bmhq_pkg::in_beat_t b);
			bmhq_pkg::out_beat_t e;
			int unsigned lim;
			lim = (cap_limit > CAPACITY) ? CAPACITY : cap_limit;
			e.extracted_key = KEY_TOP;
			e.status = bmhq_pkg::ST_OK;
			case (b.req_type)
				bmhq_pkg::REQ_INSERT: begin
					if (held >= lim) begin
						e.status = bmhq_pkg::ST_OVERFLOW;
					end else begin
						keys[held] = b.key_value;
						held++;
						sift_up(held - 1);
					end
				end
				bmhq_pkg::REQ_EXTRACT: begin
					if (held == 0)
						e.status = bmhq_pkg::ST_EMPTY;
					else
						e.extracted_key = pop_root();
				end
				bmhq_pkg::REQ_DECREASE: begin
					if (b.entry_index >= held) begin
						e.status = bmhq_pkg::ST_BAD_INDEX;
					end else begin
						keys[b.entry_index] = b.key_value;
						sift_up(32'(b.entry_index));
					end
				end
				default: begin
					if (b.entry_index >= held) begin
						e.status = bmhq_pkg::ST_BAD_INDEX;
					end else begin
						keys[b.entry_index] = KEY_BOTTOM;
						sift_up(32'(b.entry_index));
						void'(pop_root());
					end
				end
			endcase
			e.current_min = (held > 0) ? keys[0] : KEY_TOP;
			e.entry_count = 7'(held);
			expected_q.push_back(e);
		endfunction

		task report(string what, longint got_v, longint exp_v);
			$display("mismatch %s: got %0d expected %0d", what, got_v, exp_v);
			errors++;
		endtask

		task check_result(bmhq_pkg::out_beat_t got);
			bmhq_pkg::out_beat_t e;
			if (expected_q.size() == 0) begin
				report("beat with nothing pending, current_min", got.current_min, 0);
				return;
			end
			e = expected_q.pop_front();
			if (got.extracted_key !== e.extracted_key)
				report("extracted_key", got.extracted_key, e.extracted_key);
			if (got.current_min !== e.current_min)
				report("current_min", got.current_min, e.current_min);
			if (got.entry_count !== e.entry_count)
				report("entry_count", got.entry_count, e.entry_count);
			if (got.status !== e.status)
				report("status", got.status, e.status);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	bmhq_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bmhq_pkg::out_beat_t out_data;

	heap_scoreboard sb = new();

	int send_idle_pct = 15;
	int recv_idle_pct = 73;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;

	binary_min_heap_queue_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result beats are checked before the input beat of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if (in_valid && !in_stall)
				sb.note_request(in_data);
		end
	end

	// receiver side: random stall or a long hold-off when one is asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			hold_left = HOLD_CYCLES;
			out_stall = 1'b1;
		end else begin
			out_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		#2000000;
		$display("[binary_min_heap_queue_unit] ERROR");
		$finish;
	end

	function automatic bmhq_pkg::in_beat_t make_req(bmhq_pkg::req_t r, logic signed [31:0] k,
			logic [5:0] i);
		bmhq_pkg::in_beat_t b;
		b.req_type = r;
		b.key_value = k;
		b.entry_index = i;
		return b;
	endfunction

	function automatic logic signed [31:0] random_key();
		int near_zero;
		near_zero = $urandom_range(40);
		case ($urandom_range(9))
			0: return KEY_BOTTOM;
			1: return KEY_TOP;
			2, 3: return near_zero - 20;
			default: return $urandom;
		endcase
	endfunction

	function automatic bmhq_pkg::in_beat_t random_req(int w_ins, int w_ext, int w_dec,
			int w_del);
		bmhq_pkg::in_beat_t b;
		int roll;
		int unsigned cnt;
		cnt = sb.held;
		roll = $urandom_range(w_ins + w_ext + w_dec + w_del - 1);
		b.key_value = random_key();
		b.entry_index = 6'($urandom_range(63));
		if (roll < w_ins)
			b.req_type = bmhq_pkg::REQ_INSERT;
		else if (roll < w_ins + w_ext)
			b.req_type = bmhq_pkg::REQ_EXTRACT;
		else if (roll < w_ins + w_ext + w_dec)
			b.req_type = bmhq_pkg::REQ_DECREASE;
		else
			b.req_type = bmhq_pkg::REQ_DELETE;
		if ((b.req_type == bmhq_pkg::REQ_DECREASE || b.req_type == bmhq_pkg::REQ_DELETE)
				&& cnt > 0 && $urandom_range(99) >= 15)
			b.entry_index = 6'($urandom_range(cnt - 1));
		if (b.req_type == bmhq_pkg::REQ_DECREASE && b.entry_index < cnt && $urandom_range(1))
			b.key_value = sb.keys[b.entry_index] - $urandom_range(1000);
		return b;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_req(bmhq_pkg::in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_limit(logic [6:0] v);
		wait_drained();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.set_limit(v);
	endtask

	initial begin
		logic [6:0] phase_limit [PHASES];
		logic [6:0] lim;
		phase_limit = '{7'd127, 7'd64, 7'd20, 7'd1, 7'd0, 7'd100,
			7'd2, 7'd63, 7'd65, 7'd0, 7'd5, 7'd64};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_limit(bmhq_pkg::LIMIT_RESET);
		send_req(make_req(bmhq_pkg::REQ_EXTRACT, KEY_TOP, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_DECREASE, 32'sd3, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd63));
		send_req(make_req(bmhq_pkg::REQ_INSERT, KEY_TOP, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_INSERT, KEY_BOTTOM, 6'd63));
		send_req(make_req(bmhq_pkg::REQ_INSERT, 32'sd0, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_INSERT, -32'sd1, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_INSERT, 32'sd1, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_INSERT, 32'sd7, 6'd0));
		// larger value on decrease breaks the order below that slot
		send_req(make_req(bmhq_pkg::REQ_DECREASE, KEY_TOP, 6'd1));
		send_req(make_req(bmhq_pkg::REQ_DECREASE, -32'sd5, 6'd5));
		send_req(make_req(bmhq_pkg::REQ_DECREASE, 32'sd2, 6'd6));
		send_req(make_req(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_DELETE, 32'sd0, 6'(sb.held - 1)));
		send_req(make_req(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd63));
		send_req(make_req(bmhq_pkg::REQ_EXTRACT, 32'sd0, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_EXTRACT, 32'sd0, 6'd0));
		// zero limit while entries are held
		write_limit(7'd0);
		send_req(make_req(bmhq_pkg::REQ_INSERT, 32'sd5, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_EXTRACT, 32'sd0, 6'd0));
		write_limit(7'd2);
		send_req(make_req(bmhq_pkg::REQ_INSERT, KEY_BOTTOM, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_INSERT, 32'sd9, 6'd0));
		send_req(make_req(bmhq_pkg::REQ_EXTRACT, 32'sd0, 6'd0));

		for (int p = 0; p < PHASES; p++) begin
			lim = (p == 9) ? 7'($urandom_range(127)) : phase_limit[p];
			if (p < 4) begin
				send_idle_pct = 15;
				recv_idle_pct = 73;
			end else if (p < 8) begin
				send_idle_pct = 73;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_limit(lim);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((p == 1 || p == 9) && n == 30)
					hold_asked++;
				if (p == 0)
					send_req(random_req(8, 1, 1, 1));
				else if (p % 2 == 0)
					send_req(random_req(5, 3, 1, 1));
				else
					send_req(random_req(2, 4, 2, 2));
			end
		end

		wait_drained();
		repeat (24) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("[binary_min_heap_queue_unit] OK");
		else
			$display("[binary_min_heap_queue_unit] ERROR");
		$finish;
	end

endmodule
